// ===== sv/bcu_pkg.sv =====
// Package for the barometer compensation unit: constants, register codes and coefficient unpacking.
`timescale 1ns / 1ps
package bcu_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned ScaleW   = 22;
  localparam int unsigned RawW     = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned PresW    = 32;
  localparam int unsigned TempW    = 8;

  localparam logic [ScaleW-1:0] KpReset = 22'd1572864;
  localparam logic [ScaleW-1:0] KtReset = 22'd524288;

  localparam logic [CfgIdxW-1:0] RegCoef0to7   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoef8to15  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoef16to17 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPresScale  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTempScale  = 3'd4;

  typedef struct packed {
    logic signed [11:0] t0;
    logic signed [11:0] t1;
    logic signed [19:0] p00;
    logic signed [19:0] p10;
    logic signed [15:0] p01;
    logic signed [15:0] p11;
    logic signed [15:0] p20;
    logic signed [15:0] p21;
    logic signed [15:0] p30;
  } coef_t;

  // Byte 0 sits in the top byte of the first word.
  function automatic coef_t unpack_coef(input logic [63:0] w0, input logic [63:0] w1,
                                        input logic [15:0] w2);
    coef_t c;
    c.t0  = $signed(w0[63:52]);
    c.t1  = $signed(w0[51:40]);
    c.p00 = $signed(w0[39:20]);
    c.p10 = $signed(w0[19:0]);
    c.p01 = $signed(w1[63:48]);
    c.p11 = $signed(w1[47:32]);
    c.p20 = $signed(w1[31:16]);
    c.p21 = $signed(w1[15:0]);
    c.p30 = $signed(w2);
    return c;
  endfunction

endpackage

// ===== sv/bcu_mul.sv =====
// Two-stage multiplier: low 64 bits of a signed 24-bit value times a 64-bit word.
`timescale 1ns / 1ps
module bcu_mul #(
  parameter int unsigned SideW = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic signed [23:0]       a_i,
  input  logic [bcu_pkg::DataW-1:0] b_i,
  input  logic [SideW-1:0]         side_i,
  output logic [bcu_pkg::DataW-1:0] prod_o,
  output logic [SideW-1:0]         side_o
);

  logic signed [56:0] lo_d, lo_q;
  logic signed [55:0] hi_d;
  logic [31:0]        hi_q;
  logic [bcu_pkg::DataW-1:0] prod_q;
  logic [SideW-1:0]   side1_q, side2_q;

  // Split the word into an unsigned low half and a signed high half.
  assign lo_d = 57'(a_i) * $signed({1'b0, b_i[31:0]});
  assign hi_d = 56'(a_i) * 56'($signed(b_i[63:32]));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d[31:0];
      prod_q <= 64'(lo_q) + {hi_q, 32'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
    end else if (en_i) begin
      side1_q <= side_i;
      side2_q <= side1_q;
    end
  end

  assign prod_o = prod_q;
  assign side_o = side2_q;

endmodule

// ===== sv/bcu_div.sv =====
// Pipelined signed 64-bit by 22-bit divider, one quotient bit per stage, truncating toward zero.
`timescale 1ns / 1ps
module bcu_div #(
  parameter int unsigned SideW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [bcu_pkg::DataW-1:0]  dividend_i,
  input  logic [bcu_pkg::ScaleW-1:0] divisor_i,
  input  logic [SideW-1:0]           side_i,
  output logic [bcu_pkg::DataW-1:0]  quotient_o,
  output logic [SideW-1:0]           side_o
);

  localparam int unsigned Steps = bcu_pkg::DataW;
  localparam int unsigned RemW  = bcu_pkg::ScaleW;

  logic [bcu_pkg::DataW-1:0] work_q [Steps+1];
  logic [RemW-1:0]           rem_q  [Steps+1];
  logic                      neg_q  [Steps+1];
  logic [SideW-1:0]          side_q [Steps+1];
  logic [bcu_pkg::DataW-1:0] quo_q;
  logic [SideW-1:0]          side_out_q;

  // Work on the magnitude; the sign is applied again at the end.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q[0] <= dividend_i[bcu_pkg::DataW-1] ? (-dividend_i) : dividend_i;
      rem_q[0]  <= '0;
      neg_q[0]  <= dividend_i[bcu_pkg::DataW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
    end
  end

  for (genvar g = 1; g <= Steps; g++) begin : g_step
    logic [RemW:0] trial;
    logic [RemW:0] diff;
    logic          fit;

    assign trial = {rem_q[g-1], work_q[g-1][bcu_pkg::DataW-1]};
    assign diff  = trial - {1'b0, divisor_i};
    assign fit   = (trial >= {1'b0, divisor_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= fit ? diff[RemW-1:0] : trial[RemW-1:0];
        work_q[g] <= {work_q[g-1][bcu_pkg::DataW-2:0], fit};
        neg_q[g]  <= neg_q[g-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[g] <= '0;
      end else if (en_i) begin
        side_q[g] <= side_q[g-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= neg_q[Steps] ? (-work_q[Steps]) : work_q[Steps];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_out_q <= '0;
    end else if (en_i) begin
      side_out_q <= side_q[Steps];
    end
  end

  assign quotient_o = quo_q;
  assign side_o     = side_out_q;

endmodule

// ===== sv/barometer_compensation_unit.sv =====
// Three chained 66-stage dividers make up most of the pipeline from input transfer to result.
// Throughput: one item per cycle; every stage advances together when the output register is free.
// A held result stalls the whole pipeline; the input stall follows the output stall directly.
// Reset (async, active low) clears all valid bits and loads the scale registers with their
// defaults; coefficient registers reset to zero.
`timescale 1ns / 1ps
module barometer_compensation_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bcu_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bcu_pkg::DataW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bcu_pkg::RawW-1:0]            temperature_raw_i,
  input  logic [bcu_pkg::RawW-1:0]            pressure_raw_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bcu_pkg::PresW-1:0]           pressure_pa_o,
  output logic signed [bcu_pkg::TempW-1:0]    temperature_c_o
);

  localparam int unsigned DW = bcu_pkg::DataW;
  localparam int unsigned RW = bcu_pkg::RawW;

  // Configuration registers.
  logic [63:0]                coef0_q, coef1_q;
  logic [15:0]                coef2_q;
  logic [bcu_pkg::ScaleW-1:0] kp_q, kt_q, kp, kt;
  bcu_pkg::coef_t             coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef0_q <= '0;
      coef1_q <= '0;
      coef2_q <= '0;
      kp_q    <= bcu_pkg::KpReset;
      kt_q    <= bcu_pkg::KtReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcu_pkg::RegCoef0to7:   coef0_q <= cfg_data_i;
        bcu_pkg::RegCoef8to15:  coef1_q <= cfg_data_i;
        bcu_pkg::RegCoef16to17: coef2_q <= cfg_data_i[15:0];
        bcu_pkg::RegPresScale:  kp_q    <= cfg_data_i[bcu_pkg::ScaleW-1:0];
        bcu_pkg::RegTempScale:  kt_q    <= cfg_data_i[bcu_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // A zero scale divides by one.
  assign kp   = (kp_q == '0) ? bcu_pkg::ScaleW'(1) : kp_q;
  assign kt   = (kt_q == '0) ? bcu_pkg::ScaleW'(1) : kt_q;
  assign coef = bcu_pkg::unpack_coef(coef0_q, coef1_q, coef2_q);

  // Global advance: everything moves unless a result is held at the output.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 0: capture raw readings.
  logic                 v0_q;
  logic signed [RW-1:0] t0_q, p0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q <= $signed(temperature_raw_i);
      p0_q <= $signed(pressure_raw_i);
    end
  end

  // Stage 1: the four first-level products.
  logic                 v1_q;
  logic signed [RW-1:0] t1_q, p1_q;
  logic signed [DW-1:0] m1_q, m2_q, m3_q, m4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= t0_q;
      p1_q <= p0_q;
      m1_q <= 64'(p0_q) * 64'(coef.p30);
      m2_q <= 64'(p0_q) * 64'(coef.p21);
      m3_q <= 64'(t0_q) * 64'(coef.p01);
      m4_q <= 64'(coef.t1) * 64'(t0_q);
    end
  end

  // First division rank.
  localparam int unsigned SideAW = 1 + 2 * RW;
  logic [DW-1:0]     q1, q2, q3, q4;
  logic [SideAW-1:0] side_a;

  bcu_div #(.SideW(SideAW)) u_div_p30 (
    .clk_i, .rst_ni, .en_i(en), .dividend_i(m1_q), .divisor_i(kp),
    .side_i({v1_q, p1_q, t1_q}), .quotient_o(q1), .side_o(side_a)
  );
  bcu_div #(.SideW(1)) u_div_p21 (
    .clk_i, .rst_ni, .en_i(en), .dividend_i(m2_q), .divisor_i(kp),
    .side_i(1'b0), .quotient_o(q2), .side_o()
  );
  bcu_div #(.SideW(1)) u_div_p01 (
    .clk_i, .rst_ni, .en_i(en), .dividend_i(m3_q), .divisor_i(kt),
    .side_i(1'b0), .quotient_o(q3), .side_o()
  );
  bcu_div #(.SideW(1)) u_div_t1 (
    .clk_i, .rst_ni, .en_i(en), .dividend_i(m4_q), .divisor_i(kt),
    .side_i(1'b0), .quotient_o(q4), .side_o()
  );

  // Stage: add the next coefficient on the main and tail chains; the other quotients are delayed.
  logic                 v2_q;
  logic signed [RW-1:0] t2_q, p2_q;
  logic [DW-1:0]        a1_q, tail1_q, q3_2_q, q4_2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= side_a[SideAW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q    <= $signed(side_a[2*RW-1:RW]);
      t2_q    <= $signed(side_a[RW-1:0]);
      a1_q    <= 64'(coef.p20) + q1;
      tail1_q <= 64'(coef.p11) + q2;
      q3_2_q  <= q3;
      q4_2_q  <= q4;
    end
  end

  // Second multiply rank.
  localparam int unsigned SideBW = 1 + 2 * RW + 2 * DW;
  logic [DW-1:0]     pa1, ptail1;
  logic [SideBW-1:0] side_b_mul;

  bcu_mul #(.SideW(SideBW)) u_mul_a1 (
    .clk_i, .rst_ni, .en_i(en), .a_i(p2_q), .b_i(a1_q),
    .side_i({v2_q, p2_q, t2_q, q3_2_q, q4_2_q}), .prod_o(pa1), .side_o(side_b_mul)
  );
  bcu_mul #(.SideW(1)) u_mul_tail1 (
    .clk_i, .rst_ni, .en_i(en), .a_i(p2_q), .b_i(tail1_q),
    .side_i(1'b0), .prod_o(ptail1), .side_o()
  );

  // Second division rank.
  logic [DW-1:0]     q5, q6;
  logic [SideBW-1:0] side_b;

  bcu_div #(.SideW(SideBW)) u_div_a1 (
    .clk_i, .rst_ni, .en_i(en), .dividend_i(pa1), .divisor_i(kp),
    .side_i(side_b_mul), .quotient_o(q5), .side_o(side_b)
  );
  bcu_div #(.SideW(1)) u_div_tail1 (
    .clk_i, .rst_ni, .en_i(en), .dividend_i(ptail1), .divisor_i(kp),
    .side_i(1'b0), .quotient_o(q6), .side_o()
  );

  // Stage: add p10 on the main chain.
  logic                 v3_q;
  logic signed [RW-1:0] t3_q, p3_q;
  logic [DW-1:0]        a2_q, tail2_q, q3_3_q, q4_3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= side_b[SideBW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_q    <= $signed(side_b[2*DW+2*RW-1:2*DW+RW]);
      t3_q    <= $signed(side_b[2*DW+RW-1:2*DW]);
      q3_3_q  <= side_b[2*DW-1:DW];
      q4_3_q  <= side_b[DW-1:0];
      a2_q    <= 64'(coef.p10) + q5;
      tail2_q <= q6;
    end
  end

  // Third multiply rank.
  localparam int unsigned SideCW = 1 + 2 * DW;
  logic [DW-1:0]     pa2, ttail2;
  logic [SideCW-1:0] side_c_mul;

  bcu_mul #(.SideW(SideCW)) u_mul_a2 (
    .clk_i, .rst_ni, .en_i(en), .a_i(p3_q), .b_i(a2_q),
    .side_i({v3_q, q3_3_q, q4_3_q}), .prod_o(pa2), .side_o(side_c_mul)
  );
  bcu_mul #(.SideW(1)) u_mul_tail2 (
    .clk_i, .rst_ni, .en_i(en), .a_i(t3_q), .b_i(tail2_q),
    .side_i(1'b0), .prod_o(ttail2), .side_o()
  );

  // Third division rank.
  logic [DW-1:0]     q7, q8;
  logic [SideCW-1:0] side_c;

  bcu_div #(.SideW(SideCW)) u_div_a2 (
    .clk_i, .rst_ni, .en_i(en), .dividend_i(pa2), .divisor_i(kp),
    .side_i(side_c_mul), .quotient_o(q7), .side_o(side_c)
  );
  bcu_div #(.SideW(1)) u_div_tail2 (
    .clk_i, .rst_ni, .en_i(en), .dividend_i(ttail2), .divisor_i(kt),
    .side_i(1'b0), .quotient_o(q8), .side_o()
  );

  // Output register: only the low bits of each result are kept.
  logic signed [11:0]             t0_adj, t0_half;
  logic [bcu_pkg::PresW-1:0]      pres_d, pres_q;
  logic signed [bcu_pkg::TempW-1:0] temp_d, temp_q;

  // Round t0/2 toward zero.
  assign t0_adj  = coef.t0 + $signed({11'b0, coef.t0[11]});
  assign t0_half = t0_adj >>> 1;
  assign pres_d  = 32'(coef.p00) + q7[31:0] + side_c[DW+31:DW] + q8[31:0];
  assign temp_d  = $signed(8'(t0_half) + side_c[7:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side_c[SideCW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pres_q <= pres_d;
      temp_q <= temp_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pressure_pa_o   = pres_q;
  assign temperature_c_o = temp_q;

endmodule

// ===== bench/bcu_checker.sv =====
// Checker for the barometer compensation unit: predicts each result and compares.
`timescale 1ns / 1ps
module bcu_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bcu_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bcu_pkg::DataW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [bcu_pkg::RawW-1:0]          temperature_raw_i,
  input  logic [bcu_pkg::RawW-1:0]          pressure_raw_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [bcu_pkg::PresW-1:0]         pressure_pa_i,
  input  logic signed [bcu_pkg::TempW-1:0]  temperature_c_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic [bcu_pkg::PresW-1:0]        pres;
    logic signed [bcu_pkg::TempW-1:0] temp;
  } reading_t;

  logic [63:0] coef_lo, coef_mid;
  logic [15:0] coef_hi;
  logic [bcu_pkg::ScaleW-1:0] kp_reg, kt_reg;
  reading_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic signed [63:0] sx(input logic [63:0] v, input int bits);
    logic [63:0] m;
    m = (64'd1 << bits) - 64'd1;
    v = v & m;
    if (v[bits-1]) return $signed(v | ~m);
    return $signed(v);
  endfunction

  // 64-bit signed division truncating toward zero; wrapped operands allowed.
  function automatic logic signed [63:0] sdiv(input logic signed [63:0] a,
                                              input logic signed [63:0] d);
    return a / d;
  endfunction

  function automatic reading_t compensate(input logic [bcu_pkg::RawW-1:0] traw,
                                          input logic [bcu_pkg::RawW-1:0] praw);
    logic signed [63:0] t, p, kp, kt, acc, tail, tmp;
    logic signed [63:0] t0, t1, p00, p10, p01, p11, p20, p21, p30;
    reading_t r;
    t = sx(traw, 24);
    p = sx(praw, 24);
    kp = (kp_reg == 0) ? 64'sd1 : $signed({42'd0, kp_reg});
    kt = (kt_reg == 0) ? 64'sd1 : $signed({42'd0, kt_reg});
    t0  = sx(coef_lo[63:52], 12);
    t1  = sx(coef_lo[51:40], 12);
    p00 = sx(coef_lo[39:20], 20);
    p10 = sx(coef_lo[19:0], 20);
    p01 = sx(coef_mid[63:48], 16);
    p11 = sx(coef_mid[47:32], 16);
    p20 = sx(coef_mid[31:16], 16);
    p21 = sx(coef_mid[15:0], 16);
    p30 = sx(coef_hi, 16);
    acc = p20 + sdiv(p * p30, kp);
    acc = p10 + sdiv(p * acc, kp);
    acc = p00 + sdiv(p * acc, kp);
    acc = acc + sdiv(t * p01, kt);
    tail = p11 + sdiv(p * p21, kp);
    tail = sdiv(p * tail, kp);
    tail = sdiv(t * tail, kt);
    acc = acc + tail;
    tmp = sdiv(t0, 64'sd2) + sdiv(t1 * t, kt);
    r.pres = acc[31:0];
    r.temp = tmp[7:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      coef_lo = '0; coef_mid = '0; coef_hi = '0;
      kp_reg = bcu_pkg::KpReset; kt_reg = bcu_pkg::KtReset;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (pressure_pa_i !== want.pres)
            report_mismatch($sformatf("pressure got %0h want %0h", pressure_pa_i, want.pres));
          if (temperature_c_i !== want.temp)
            report_mismatch($sformatf("temperature got %0d want %0d",
                                      temperature_c_i, want.temp));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(compensate(temperature_raw_i, pressure_raw_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bcu_pkg::RegCoef0to7:   coef_lo = cfg_data_i;
          bcu_pkg::RegCoef8to15:  coef_mid = cfg_data_i;
          bcu_pkg::RegCoef16to17: coef_hi = cfg_data_i[15:0];
          bcu_pkg::RegPresScale:  kp_reg = cfg_data_i[bcu_pkg::ScaleW-1:0];
          bcu_pkg::RegTempScale:  kt_reg = cfg_data_i[bcu_pkg::ScaleW-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== bench/tb.sv =====
// Testbench top for the barometer compensation unit: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int Latency = 207;
  localparam int IdleLimit = 20000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [bcu_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [bcu_pkg::DataW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [bcu_pkg::RawW-1:0] temperature_raw_i, pressure_raw_i;
  logic [bcu_pkg::PresW-1:0] pressure_pa_o;
  logic signed [bcu_pkg::TempW-1:0] temperature_c_o;
  int fail_count, pending, idle_cycles;

  barometer_compensation_unit uut (.*);

  bcu_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .temperature_raw_i, .pressure_raw_i,
    .out_valid_i(out_valid_o), .out_stall_i, .pressure_pa_i(pressure_pa_o),
    .temperature_c_i(temperature_c_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Watchdog: end the run after too many cycles with no transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("barometer_compensation_unit regression: fail");
      $finish;
    end
  end

  // Receiver stalls at random throughout the run.
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = gap_len();
      @(negedge clk_i);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
  end

  task automatic write_reg(input logic [bcu_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  task automatic send_reading(input logic [23:0] t, input logic [23:0] p, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    temperature_raw_i <= t;
    pressure_raw_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] rand_raw();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_scale();
    case ($urandom_range(0, 6))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'h3FFFFF;
      3: return {$urandom(), $urandom()};
      4: return 64'($urandom_range(1, 64));
      default: return 64'($urandom_range(1, 22'h3FFFFF));
    endcase
  endfunction

  initial begin
    logic [23:0] edge_vals[4];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; temperature_raw_i = '0; pressure_raw_i = '0;
    idle_cycles = 0;
    edge_vals = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset defaults, then realistic and extreme coefficients.
    foreach (edge_vals[i]) send_reading(edge_vals[i], edge_vals[3 - i], 1'b0);
    in_valid_i <= 1'b0;
    drain();
    write_reg(bcu_pkg::RegCoef0to7, 64'h8001_2345_6789_ABCD);  // most negative t0
    write_reg(bcu_pkg::RegCoef8to15, 64'h8000_7FFF_FFFF_0001);
    write_reg(bcu_pkg::RegCoef16to17, 64'h8000);
    foreach (edge_vals[i])
      for (int j = 0; j < 4; j++) send_reading(edge_vals[i], edge_vals[j], 1'b0);
    in_valid_i <= 1'b0;
    drain();
    write_reg(bcu_pkg::RegPresScale, 64'd0);  // zero scale acts as one; products wrap
    write_reg(bcu_pkg::RegTempScale, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bcu_pkg::RegCoef0to7, 64'hFFFF_FFFF_FFFF_FFFF);
    foreach (edge_vals[i]) send_reading(edge_vals[i], edge_vals[i], 1'b0);
    in_valid_i <= 1'b0;
    drain();

    // Random phases with fresh settings.
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(bcu_pkg::RegCoef0to7, rand_word());
      write_reg(bcu_pkg::RegCoef8to15, rand_word());
      write_reg(bcu_pkg::RegCoef16to17, rand_word());
      write_reg(bcu_pkg::RegPresScale, rand_scale());
      write_reg(bcu_pkg::RegTempScale, rand_scale());
      for (int k = 0; k < 100; k++) begin
        send_reading(rand_raw(), rand_raw(), ph % 4 != 3);
        // Hold off until all expected results have come.
        if (k == 50 && ph == 2) begin
          in_valid_i <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
      drain();
    end

    if (fail_count == 0)
      $display("barometer_compensation_unit regression: pass");
    else
      $display("barometer_compensation_unit regression: fail");
    $finish;
  end
endmodule
